FILE: sv/zrp_pkg.sv
// Package for the zero-range process step core.
// Holds the fixed field widths, register and function codes, and the state type.
// No dependencies.
package zrp_pkg;

    localparam int SITE_W     = 10;
    localparam int CNT_IN_W   = 16;
    localparam int DICE_W     = 32;
    localparam int STEP_W     = 32;
    localparam int BULK_OUT_W = 16;
    localparam int GAIN_W     = 16;
    localparam int TOTAL_W    = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int ACTIVE_W   = 11;
    localparam int BSTART_W   = 10;
    localparam int BLEN_W     = 11;
    localparam int BLIMIT_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SITES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BULK_START   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BULK_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BULK_LIMIT   = 3'd4;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_RD,
        S_LD_CAP,
        S_LD_DIV,
        S_LD_WR,
        S_MUL_LO,
        S_MUL_HI,
        S_SCAN,
        S_PICK,
        S_RD_CUR,
        S_CAP_CUR,
        S_CAP_TO,
        S_DIV_CUR,
        S_DIV_TO,
        S_WR_CUR,
        S_WR_TO,
        S_RC_RD,
        S_RC_CAP,
        S_RC_DIV,
        S_OUT
    } t_state;

endpackage

FILE: sv/zrp_in_if.sv
// Input item channel: valid/ready handshake with load and step fields.
// Depends on zrp_pkg.
interface zrp_in_if;
    import zrp_pkg::*;
    logic              valid;
    logic              ready;
    logic              func;
    logic [SITE_W-1:0] site;
    logic [CNT_IN_W-1:0] count;
    logic [DICE_W-1:0] dice;
    logic              go_right;

    modport source (output valid, func, site, count, dice, go_right, input ready);
    modport sink   (input valid, func, site, count, dice, go_right, output ready);
endinterface

FILE: sv/zrp_out_if.sv
// Result item channel: valid/ready handshake with hop and bulk status fields.
// Depends on zrp_pkg.
interface zrp_out_if;
    import zrp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [SITE_W-1:0]     from_site;
    logic [SITE_W-1:0]     to_site;
    logic                  moved;
    logic [BULK_OUT_W-1:0] bulk_count;
    logic                  supercritical;
    logic [STEP_W-1:0]     step_count;

    modport source (output valid, from_site, to_site, moved, bulk_count, supercritical,
                    step_count, input ready);
    modport sink   (input valid, from_site, to_site, moved, bulk_count, supercritical,
                    step_count, output ready);
endinterface

FILE: sv/zrp_rate.sv
// Site rate unit: rate(n) = 2^F + floor((b << (F-8)) / n), zero for n = 0.
// Restoring divider, one quotient bit per cycle. Depends on zrp_pkg.
module zrp_rate #(
    parameter int COUNT_BITS     = 16,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [COUNT_BITS-1:0]         i_n,
    input  logic [zrp_pkg::GAIN_W-1:0]    i_gain,
    output logic                          o_done,
    output logic [RATE_FRAC_BITS+8:0]     o_rate
);
    import zrp_pkg::*;

    localparam int NW = RATE_FRAC_BITS + 8;
    localparam int RW = RATE_FRAC_BITS + 9;
    localparam int CW = $clog2(NW + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [COUNT_BITS-1:0] r_den;
    logic [COUNT_BITS-1:0] r_rem;
    logic [NW-1:0]         r_quo;
    logic [RW-1:0]         r_rate;

    logic [COUNT_BITS:0]   w_t;
    logic                  w_ge;
    logic [COUNT_BITS-1:0] w_rem_n;
    logic [NW-1:0]         w_quo_n;

    always_comb begin
        w_t     = {r_rem, r_quo[NW-1]};
        w_ge    = (w_t >= {1'b0, r_den});
        w_rem_n = w_ge ? COUNT_BITS'(w_t - {1'b0, r_den}) : COUNT_BITS'(w_t);
        w_quo_n = {r_quo[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_n == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den <= i_n;
            r_rem <= '0;
            r_quo <= NW'(i_gain) << (RATE_FRAC_BITS - 8);
            if (i_n == '0) begin
                r_rate <= '0;
            end
        end else if (r_busy) begin
            r_rem <= w_rem_n;
            r_quo <= w_quo_n;
            if (r_cnt == CW'(NW - 1)) begin
                r_rate <= (RW'(1) << RATE_FRAC_BITS) + RW'(w_quo_n);
            end
        end
    end

    assign o_done = r_done;
    assign o_rate = r_rate;

endmodule

FILE: sv/zero_range_process_step_core.sv
// Zero-range process step core. A load reads the site, makes one divider pass in
// zrp_rate and writes the site back. A step scans the rate memory (one site a cycle)
// and makes two divider passes in zrp_rate. One item at a time.
// After reset a clearing pass zeroes both memories; no item is taken meanwhile.
// A write of registers 0 to 3 starts a recompute of every site, during which no
// item is taken.
module zero_range_process_step_core #(
    parameter int MAX_SITES      = 1024,
    parameter int COUNT_BITS     = 16,
    parameter int RATE_FRAC_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    zrp_in_if.sink                          i_in,
    zrp_out_if.source                       o_out,
    input  logic                            i_cfg_we,
    input  logic [zrp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [zrp_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import zrp_pkg::*;

    localparam int IW = $clog2(MAX_SITES);
    localparam int LW = IW + 1;
    localparam int RW = RATE_FRAC_BITS + 9;
    localparam int BW = COUNT_BITS + IW + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    t_state r_state, n_state;

    logic [COUNT_BITS-1:0] r_occ_mem  [MAX_SITES];
    logic [RW-1:0]         r_rate_mem [MAX_SITES];
    logic [COUNT_BITS-1:0] r_occ_q;
    logic [RW-1:0]         r_rate_q;

    logic [ACTIVE_W-1:0] r_active;
    logic [GAIN_W-1:0]   r_gain;
    logic [BSTART_W-1:0] r_bstart;
    logic [BLEN_W-1:0]   r_blen;
    logic [BLIMIT_W-1:0] r_blimit;
    logic                r_recalc;

    logic [TOTAL_W-1:0] r_total;
    logic [BW-1:0]      r_bulk;
    logic [STEP_W-1:0]  r_hops;

    logic [LW-1:0] r_idx;
    logic          r_pvld;
    logic [IW-1:0] r_pidx;
    logic          r_found;

    logic [IW-1:0]         r_site;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [DICE_W-1:0]     r_dice;
    logic                  r_right;
    logic [63:0]           r_plo;
    logic [TOTAL_W-1:0]    r_target;
    logic [TOTAL_W-1:0]    r_prefix;
    logic [IW-1:0]         r_cur;
    logic [IW-1:0]         r_last;
    logic [IW-1:0]         r_to;
    logic [COUNT_BITS-1:0] r_occ_c;
    logic [COUNT_BITS-1:0] r_occ_t;
    logic [RW-1:0]         r_rate_c;
    logic [RW-1:0]         r_rate_t;
    logic [RW-1:0]         r_nr_c;
    logic [RW-1:0]         r_nr_t;
    logic [SITE_W-1:0]     r_from;
    logic [SITE_W-1:0]     r_tosite;
    logic                  r_moved;

    logic                  r_ovalid;
    logic [SITE_W-1:0]     r_o_from;
    logic [SITE_W-1:0]     r_o_to;
    logic                  r_o_moved;
    logic [BULK_OUT_W-1:0] r_o_bulk;
    logic                  r_o_super;
    logic [STEP_W-1:0]     r_o_steps;

    logic [31:0]           w_act32;
    logic [31:0]           w_ring32;
    logic [LW-1:0]         w_ring;
    logic                  w_in_acc;
    logic                  w_site_ok;
    logic [COUNT_BITS-1:0] w_cnt_sat;
    logic [TOTAL_W-1:0]    w_sum;
    logic [IW-1:0]         w_pick;
    logic [LW-1:0]         w_pick_inc;
    logic [IW-1:0]         w_to;
    logic                  w_ok;

    logic [IW-1:0]         w_raddr;
    logic                  w_we;
    logic [IW-1:0]         w_waddr;
    logic [COUNT_BITS-1:0] w_wocc;
    logic [RW-1:0]         w_wrate;
    logic                  w_ru_start;
    logic [COUNT_BITS-1:0] w_ru_n;
    logic                  w_ru_done;
    logic [RW-1:0]         w_ru_rate;

    function automatic logic f_in_bulk(input logic [31:0] s, input logic [31:0] l,
                                       input logic [31:0] bs, input logic [31:0] bl);
        return (s < l) && (s >= bs) && (s < bs + bl);
    endfunction

    zrp_rate #(
        .COUNT_BITS     (COUNT_BITS),
        .RATE_FRAC_BITS (RATE_FRAC_BITS)
    ) u_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ru_start),
        .i_n     (w_ru_n),
        .i_gain  (r_gain),
        .o_done  (w_ru_done),
        .o_rate  (w_ru_rate)
    );

    always_comb begin
        w_act32 = 32'(r_active);
        if (w_act32 < 32'd2) begin
            w_ring32 = 32'd2;
        end else if (w_act32 > 32'(MAX_SITES)) begin
            w_ring32 = 32'(MAX_SITES);
        end else begin
            w_ring32 = w_act32;
        end
        w_ring     = LW'(w_ring32);
        w_in_acc   = i_in.valid && i_in.ready;
        w_site_ok  = 32'(i_in.site) < 32'(MAX_SITES);
        w_cnt_sat  = (32'(i_in.count) > 32'(CMAX)) ? CMAX : COUNT_BITS'(i_in.count);
        w_sum      = r_prefix + TOTAL_W'(r_rate_q);
        w_pick     = r_found ? r_cur : r_last;
        w_pick_inc = LW'(w_pick) + 1'b1;
        if (r_right) begin
            w_to = (w_pick_inc == w_ring) ? '0 : IW'(w_pick_inc);
        end else begin
            w_to = (w_pick == '0) ? IW'(w_ring - 1'b1) : w_pick - 1'b1;
        end
        w_ok = (r_occ_c != '0) && (r_occ_q != CMAX);
    end

    assign i_in.ready = (r_state == S_IDLE) && !r_recalc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        w_raddr    = r_site;
        w_we       = 1'b0;
        w_waddr    = r_cur;
        w_wocc     = '0;
        w_wrate    = '0;
        w_ru_start = 1'b0;
        w_ru_n     = r_cnt;
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[IW-1:0];
                if (r_idx == LW'(MAX_SITES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (r_recalc) begin
                    n_state = S_RC_RD;
                end else if (w_in_acc) begin
                    if (i_in.func == FUNC_LOAD) begin
                        n_state = w_site_ok ? S_LD_RD : S_OUT;
                    end else begin
                        n_state = (r_total == '0) ? S_OUT : S_MUL_LO;
                    end
                end
            end
            S_LD_RD: begin
                w_raddr = r_site;
                n_state = S_LD_CAP;
            end
            S_LD_CAP: begin
                w_ru_start = 1'b1;
                w_ru_n     = r_cnt;
                n_state    = S_LD_DIV;
            end
            S_LD_DIV: begin
                if (w_ru_done) begin
                    n_state = S_LD_WR;
                end
            end
            S_LD_WR: begin
                w_we    = 1'b1;
                w_waddr = r_site;
                w_wocc  = r_cnt;
                w_wrate = r_nr_c;
                n_state = S_OUT;
            end
            S_MUL_LO: n_state = S_MUL_HI;
            S_MUL_HI: n_state = S_SCAN;
            S_SCAN: begin
                w_raddr = r_idx[IW-1:0];
                if (!r_pvld && r_idx >= w_ring) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: n_state = S_RD_CUR;
            S_RD_CUR: begin
                w_raddr = r_cur;
                n_state = S_CAP_CUR;
            end
            S_CAP_CUR: begin
                w_raddr = r_to;
                n_state = S_CAP_TO;
            end
            S_CAP_TO: begin
                if (w_ok) begin
                    w_ru_start = 1'b1;
                    w_ru_n     = r_occ_c - 1'b1;
                    n_state    = S_DIV_CUR;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_DIV_CUR: begin
                if (w_ru_done) begin
                    w_ru_start = 1'b1;
                    w_ru_n     = r_occ_t + 1'b1;
                    n_state    = S_DIV_TO;
                end
            end
            S_DIV_TO: begin
                if (w_ru_done) begin
                    n_state = S_WR_CUR;
                end
            end
            S_WR_CUR: begin
                w_we    = 1'b1;
                w_waddr = r_cur;
                w_wocc  = r_occ_c - 1'b1;
                w_wrate = r_nr_c;
                n_state = S_WR_TO;
            end
            S_WR_TO: begin
                w_we    = 1'b1;
                w_waddr = r_to;
                w_wocc  = r_occ_t + 1'b1;
                w_wrate = r_nr_t;
                n_state = S_OUT;
            end
            S_RC_RD: begin
                w_raddr = r_idx[IW-1:0];
                n_state = S_RC_CAP;
            end
            S_RC_CAP: begin
                w_ru_start = 1'b1;
                w_ru_n     = r_occ_q;
                n_state    = S_RC_DIV;
            end
            S_RC_DIV: begin
                if (w_ru_done) begin
                    w_we    = 1'b1;
                    w_waddr = r_idx[IW-1:0];
                    w_wocc  = r_occ_c;
                    w_wrate = w_ru_rate;
                    n_state = (r_idx == LW'(MAX_SITES - 1)) ? S_IDLE : S_RC_RD;
                end
            end
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // site memories
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_occ_mem[w_waddr]  <= w_wocc;
            r_rate_mem[w_waddr] <= w_wrate;
        end
        r_occ_q  <= r_occ_mem[w_raddr];
        r_rate_q <= r_rate_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_W'(1024);
            r_gain   <= GAIN_W'(1024);
            r_bstart <= BSTART_W'(409);
            r_blen   <= BLEN_W'(204);
            r_blimit <= BLIMIT_W'(102);
            r_recalc <= 1'b0;
            r_total  <= '0;
            r_bulk   <= '0;
            r_hops   <= '0;
            r_idx    <= '0;
            r_pvld   <= 1'b0;
            r_found  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ACTIVE_SITES: r_active <= ACTIVE_W'(i_cfg_wdata);
                    CFG_RATE_GAIN:    r_gain   <= GAIN_W'(i_cfg_wdata);
                    CFG_BULK_START:   r_bstart <= BSTART_W'(i_cfg_wdata);
                    CFG_BULK_LENGTH:  r_blen   <= BLEN_W'(i_cfg_wdata);
                    CFG_BULK_LIMIT:   r_blimit <= BLIMIT_W'(i_cfg_wdata);
                    default: ;
                endcase
            end
            if (i_cfg_we && i_cfg_idx <= CFG_BULK_LENGTH) begin
                r_recalc <= 1'b1;
            end else if (r_state == S_IDLE && r_recalc) begin
                r_recalc <= 1'b0;
            end

            if (r_state == S_OUT && n_state == S_IDLE) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: r_idx <= r_idx + 1'b1;
                S_IDLE: begin
                    r_idx   <= '0;
                    r_pvld  <= 1'b0;
                    r_found <= 1'b0;
                    if (r_recalc) begin
                        r_total <= '0;
                        r_bulk  <= '0;
                    end
                end
                S_SCAN: begin
                    if (r_idx < w_ring) begin
                        r_idx  <= r_idx + 1'b1;
                        r_pvld <= 1'b1;
                    end else begin
                        r_pvld <= 1'b0;
                    end
                    if (r_pvld && !r_found && r_target < w_sum) begin
                        r_found <= 1'b1;
                    end
                end
                S_LD_WR: begin
                    if (LW'(r_site) < w_ring) begin
                        r_total <= r_total - TOTAL_W'(r_rate_c) + TOTAL_W'(r_nr_c);
                        if (f_in_bulk(32'(r_site), w_ring32, 32'(r_bstart), 32'(r_blen))) begin
                            r_bulk <= r_bulk - BW'(r_occ_c) + BW'(r_cnt);
                        end
                    end
                end
                S_WR_CUR: begin
                    r_total <= r_total - TOTAL_W'(r_rate_c) + TOTAL_W'(r_nr_c);
                    if (f_in_bulk(32'(r_cur), w_ring32, 32'(r_bstart), 32'(r_blen))) begin
                        r_bulk <= r_bulk - 1'b1;
                    end
                end
                S_WR_TO: begin
                    r_total <= r_total - TOTAL_W'(r_rate_t) + TOTAL_W'(r_nr_t);
                    if (f_in_bulk(32'(r_to), w_ring32, 32'(r_bstart), 32'(r_blen))) begin
                        r_bulk <= r_bulk + 1'b1;
                    end
                    if (r_hops != '1) begin
                        r_hops <= r_hops + 1'b1;
                    end
                end
                S_RC_DIV: begin
                    if (w_ru_done) begin
                        r_idx <= r_idx + 1'b1;
                        if (r_idx < w_ring) begin
                            r_total <= r_total + TOTAL_W'(w_ru_rate);
                            if (f_in_bulk(32'(r_idx), w_ring32, 32'(r_bstart),
                                          32'(r_blen))) begin
                                r_bulk <= r_bulk + BW'(r_occ_c);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_site    <= IW'(i_in.site);
                    r_cnt     <= w_cnt_sat;
                    r_dice    <= i_in.dice;
                    r_right   <= i_in.go_right;
                    r_moved   <= 1'b0;
                    if (i_in.func == FUNC_LOAD) begin
                        r_from   <= i_in.site;
                        r_tosite <= i_in.site;
                    end else begin
                        r_from   <= '0;
                        r_tosite <= '0;
                    end
                end
            end
            S_LD_CAP: begin
                r_occ_c  <= r_occ_q;
                r_rate_c <= r_rate_q;
            end
            S_LD_DIV: begin
                if (w_ru_done) begin
                    r_nr_c <= w_ru_rate;
                end
            end
            S_MUL_LO: r_plo <= r_dice * r_total[31:0];
            S_MUL_HI: begin
                r_target <= TOTAL_W'(40'(r_dice) * 40'(r_total[TOTAL_W-1:32]))
                            + TOTAL_W'(r_plo[63:32]);
                r_prefix <= '0;
                r_last   <= '0;
                r_cur    <= '0;
            end
            S_SCAN: begin
                r_pidx <= r_idx[IW-1:0];
                if (r_pvld) begin
                    r_prefix <= w_sum;
                    if (r_rate_q != '0) begin
                        r_last <= r_pidx;
                    end
                    if (!r_found && r_target < w_sum) begin
                        r_cur <= r_pidx;
                    end
                end
            end
            S_PICK: begin
                r_cur <= w_pick;
                r_to  <= w_to;
            end
            S_CAP_CUR: begin
                r_occ_c  <= r_occ_q;
                r_rate_c <= r_rate_q;
            end
            S_CAP_TO: begin
                r_occ_t  <= r_occ_q;
                r_rate_t <= r_rate_q;
                r_from   <= SITE_W'(r_cur);
                r_tosite <= SITE_W'(r_to);
            end
            S_DIV_CUR: begin
                if (w_ru_done) begin
                    r_nr_c <= w_ru_rate;
                end
            end
            S_DIV_TO: begin
                if (w_ru_done) begin
                    r_nr_t <= w_ru_rate;
                end
            end
            S_WR_TO: r_moved <= 1'b1;
            S_RC_CAP: r_occ_c <= r_occ_q;
            S_OUT: begin
                if (!r_ovalid || o_out.ready) begin
                    r_o_from  <= r_from;
                    r_o_to    <= r_tosite;
                    r_o_moved <= r_moved;
                    r_o_bulk  <= (64'(r_bulk) > 64'(16'hFFFF)) ? '1 : BULK_OUT_W'(r_bulk);
                    r_o_super <= 64'(r_bulk) > 64'(r_blimit);
                    r_o_steps <= r_hops;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.from_site     = r_o_from;
    assign o_out.to_site       = r_o_to;
    assign o_out.moved         = r_o_moved;
    assign o_out.bulk_count    = r_o_bulk;
    assign o_out.supercritical = r_o_super;
    assign o_out.step_count    = r_o_steps;

endmodule

FILE: sv/zrp_chk.sv
// Port checker for the zero-range process step core, bound to the top level.
// Depends on zrp_in_if, zrp_out_if and zero_range_process_step_core.
module zrp_chk (
    input logic    i_clk,
    input logic    i_rst_n,
    zrp_in_if.sink  i_in,
    zrp_out_if.source o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.step_count)
            && $stable(o_out.from_site))
        else $error("result item changed while stalled");

    a_clear_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_in.ready && !o_out.valid)
        else $error("item taken or result shown during clearing pass");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("second item taken while one is in work");

    a_super_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.supercritical |-> o_out.bulk_count != '0)
        else $error("supercritical with empty bulk");

endmodule

bind zero_range_process_step_core zrp_chk u_zrp_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

FILE: sim/zrp_step_checker.sv
// Checker for the zero-range process step core: watches the item channels and the
// register port, predicts each result and compares it field by field.
// Depends on zrp_pkg, zrp_in_if and zrp_out_if.
`timescale 1ns / 1ps
module zrp_step_checker
    import zrp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    zrp_in_if                     i_in,
    zrp_out_if                    i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_fail_cnt,
    output int                    o_pending
);

    typedef struct packed {
        logic [SITE_W-1:0]     from_site;
        logic [SITE_W-1:0]     to_site;
        logic                  moved;
        logic [BULK_OUT_W-1:0] bulk_count;
        logic                  supercritical;
        logic [STEP_W-1:0]     step_count;
    } t_hop_result;

    logic [15:0]          occ [1024];
    logic [TOTAL_W-1:0]   rate_sum;
    logic [31:0]          bulk_sum;
    logic [STEP_W-1:0]    hops;
    logic [ACTIVE_W-1:0]  r_active;
    logic [GAIN_W-1:0]    r_gain;
    logic [BSTART_W-1:0]  r_bstart;
    logic [BLEN_W-1:0]    r_blen;
    logic [BLIMIT_W-1:0]  r_blimit;
    t_hop_result          hop_q[$];

    assign o_pending = hop_q.size();

    function automatic int ring_len();
        if (r_active < 2) return 2;
        if (r_active > 1024) return 1024;
        return r_active;
    endfunction

    function automatic longint unsigned rate_of(int n);
        longint unsigned num;
        num = longint'(r_gain) << 8;
        if (n == 0) return 0;
        return (64'd1 << 16) + num / longint'(n);
    endfunction

    function automatic bit in_region(int s);
        return s < ring_len() && s >= r_bstart && s < int'(r_bstart) + int'(r_blen);
    endfunction

    function automatic void rebuild();
        rate_sum = '0;
        bulk_sum = '0;
        for (int i = 0; i < ring_len(); i++) begin
            rate_sum = TOTAL_W'(rate_sum + rate_of(occ[i]));
            if (in_region(i)) bulk_sum = bulk_sum + occ[i];
        end
    endfunction

    function automatic void put_count(int s, int n);
        if (s < ring_len()) begin
            rate_sum = TOTAL_W'(rate_sum - rate_of(occ[s]) + rate_of(n));
            if (in_region(s)) bulk_sum = bulk_sum - occ[s] + 32'(n);
        end
        occ[s] = 16'(n);
    endfunction

    function automatic t_hop_result predict_hop(logic func, logic [SITE_W-1:0] site,
                                                logic [CNT_IN_W-1:0] count,
                                                logic [DICE_W-1:0] dice, logic go_right);
        t_hop_result r;
        longint unsigned aim, acc;
        int l, cur, last, dst;
        bit hit;
        r = '0;
        l = ring_len();
        if (func == FUNC_LOAD) begin
            put_count(site, count);
            r.from_site = site;
            r.to_site = site;
        end else if (rate_sum != 0) begin
            aim = longint'(dice) * longint'(rate_sum[39:32])
                + ((longint'(dice) * longint'(rate_sum[31:0])) >> 32);
            acc = 0;
            cur = 0;
            last = 0;
            hit = 0;
            for (int i = 0; i < l; i++) begin
                if (occ[i] != 0) last = i;
                acc = acc + rate_of(occ[i]);
                if (!hit && aim < acc) begin
                    cur = i;
                    hit = 1;
                end
            end
            if (!hit) cur = last;
            if (go_right) dst = (cur + 1 == l) ? 0 : cur + 1;
            else dst = (cur == 0) ? l - 1 : cur - 1;
            r.from_site = SITE_W'(cur);
            r.to_site = SITE_W'(dst);
            if (occ[cur] != 0 && occ[dst] != 16'hFFFF) begin
                put_count(cur, occ[cur] - 1);
                put_count(dst, occ[dst] + 1);
                r.moved = 1'b1;
                if (hops != '1) hops = hops + 1;
            end
        end
        r.bulk_count = (bulk_sum > 32'hFFFF) ? 16'hFFFF : bulk_sum[15:0];
        r.supercritical = bulk_sum > r_blimit;
        r.step_count = hops;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_hop_result want;
        t_hop_result got;
        if (!i_rst_n) begin
            foreach (occ[i]) occ[i] = '0;
            rate_sum = '0;
            bulk_sum = '0;
            hops = '0;
            r_active = 11'd1024;
            r_gain = 16'd1024;
            r_bstart = 10'd409;
            r_blen = 11'd204;
            r_blimit = 16'd102;
            hop_q.delete();
            o_fail_cnt = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.from_site, i_out.to_site, i_out.moved, i_out.bulk_count,
                        i_out.supercritical, i_out.step_count};
                if (hop_q.size() == 0) begin
                    $display("%0t: result with none expected: %p", $time, got);
                    o_fail_cnt++;
                end else begin
                    want = hop_q.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected %p actual %p", $time, want, got);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ACTIVE_SITES: begin r_active = i_cfg_wdata[ACTIVE_W-1:0]; rebuild(); end
                    CFG_RATE_GAIN:    begin r_gain = i_cfg_wdata; rebuild(); end
                    CFG_BULK_START:   begin r_bstart = i_cfg_wdata[BSTART_W-1:0]; rebuild(); end
                    CFG_BULK_LENGTH:  begin r_blen = i_cfg_wdata[BLEN_W-1:0]; rebuild(); end
                    CFG_BULK_LIMIT:   r_blimit = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                hop_q.push_back(predict_hop(i_in.func, i_in.site, i_in.count, i_in.dice,
                                            i_in.go_right));
        end
    end

endmodule

FILE: sim/tb_zero_range_process_step_core.sv
// Testbench top for the zero-range process step core: clock, reset, register writes,
// load/step item stimulus with random idling and back-pressure, and the verdict.
// Depends on zrp_pkg, zrp_in_if, zrp_out_if, zrp_step_checker and the core.
`timescale 1ns / 1ps
module tb_zero_range_process_step_core;
    import zrp_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    int                    fail_cnt;
    int                    pending;
    int                    cycles = 0;
    int                    results_seen = 0;
    int                    ring;
    bit                    calm;
    bit                    hold_done = 0;

    zrp_in_if  in_ch();
    zrp_out_if out_ch();

    zero_range_process_step_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    zrp_step_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (out_ch.valid && out_ch.ready) results_seen <= results_seen + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (!hold_done && results_seen >= 300) begin
                out_ch.ready <= 1'b0;
                repeat (2000) @(posedge i_clk);
                hold_done = 1;
            end
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
        end
    end

    task automatic send_item(logic func, int site, int count, logic [31:0] dice,
                             logic go_right);
        if (!calm && $urandom_range(0, 99) < 6) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.func <= func;
        in_ch.site <= SITE_W'(site);
        in_ch.count <= CNT_IN_W'(count);
        in_ch.dice <= dice;
        in_ch.go_right <= go_right;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic load(int site, int count);
        send_item(FUNC_LOAD, site, count, $urandom, 1'($urandom_range(0, 1)));
    endtask

    task automatic step(logic [31:0] dice, logic go_right);
        send_item(FUNC_STEP, $urandom_range(0, 1023), $urandom_range(0, 65535), dice, go_right);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // register write when idle, then a load item that waits out any recompute
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val, int site, int count);
        drain();
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= CFG_DATA_W'(val);
        @(posedge i_clk);
        cfg_we <= 1'b0;
        load(site, count);
    endtask

    task automatic random_phase(int items);
        int pick;
        int s;
        int c;
        for (int k = 0; k < items; k++) begin
            calm = (k >= 60 && k < 140);
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, ring - 1);
                c = $urandom_range(0, 99);
                if (c < 5) c = $urandom_range(0, 65535);
                else if (c < 7) c = 65535;
                else c = $urandom_range(0, 6);
                load(s, c);
            end else begin
                step($urandom, 1'($urandom_range(0, 1)));
            end
        end
        calm = 0;
    endtask

    initial begin
        calm = 0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_wdata = '0;
        in_ch.valid = 1'b0;
        in_ch.func = FUNC_LOAD;
        in_ch.site = '0;
        in_ch.count = '0;
        in_ch.dice = '0;
        in_ch.go_right = 1'b0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed
        step(32'h0, 1'b1);
        write_reg(CFG_ACTIVE_SITES, 8, 0, 1);
        step(32'h0, 1'b0);
        step(32'h0, 1'b1);
        load(1, 65535);
        step(32'h0, 1'b1);
        load(9, 5);
        load(1023, 3);
        load(0, 0);
        load(1, 0);
        step(32'hFFFF_FFFF, 1'b0);
        load(3, 2);
        step(32'hFFFF_FFFF, 1'b1);
        write_reg(CFG_RATE_GAIN, 0, 4, 1);
        step(32'h8000_0000, 1'b0);
        write_reg(CFG_RATE_GAIN, 65535, 5, 65535);
        step(32'hFFFF_FFFF, 1'b1);
        write_reg(CFG_ACTIVE_SITES, 1, 1, 4);
        step(32'h0, 1'b0);
        write_reg(CFG_ACTIVE_SITES, 2047, 512, 7);
        step(32'h7FFF_FFFF, 1'b1);
        write_reg(CFG_BULK_START, 0, 0, 9);
        write_reg(CFG_BULK_LENGTH, 1, 0, 65535);
        write_reg(CFG_BULK_LIMIT, 0, 0, 3);
        write_reg(CFG_SPARE_IDX, 16'hFFFF, 2, 1);

        ring = 1024;
        write_reg(CFG_RATE_GAIN, 1024, 410, 50);
        write_reg(CFG_BULK_START, 409, 420, 60);
        write_reg(CFG_BULK_LENGTH, 204, 500, 2);
        write_reg(CFG_BULK_LIMIT, 102, 100, 3);
        random_phase(170);

        ring = 37;
        write_reg(CFG_ACTIVE_SITES, 37, 12, 4);
        write_reg(CFG_RATE_GAIN, 512, 20, 6);
        write_reg(CFG_BULK_START, 10, 15, 2);
        write_reg(CFG_BULK_LENGTH, 1024, 30, 1);
        write_reg(CFG_BULK_LIMIT, 48, 5, 3);
        random_phase(170);

        ring = 300;
        write_reg(CFG_ACTIVE_SITES, 300, 299, 5);
        write_reg(CFG_RATE_GAIN, 200, 0, 4);
        write_reg(CFG_BULK_START, 1023, 150, 2);
        write_reg(CFG_BULK_LENGTH, 1, 1023, 8);
        write_reg(CFG_BULK_LIMIT, 65535, 7, 1);
        random_phase(150);

        drain();
        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
